/* sv/spise_pkg.sv */
`timescale 1ns / 1ps
package spise_pkg;

  localparam logic FuncStart = 1'b0;
  localparam logic FuncTick  = 1'b1;

  localparam logic [1:0] DirFullDuplex = 2'd0;
  localparam logic [1:0] DirRxOnly     = 2'd1;
  localparam logic [1:0] DirTxOneLine  = 2'd2;
  localparam logic [1:0] DirRxOneLine  = 2'd3;

  localparam logic [1:0] RegSpiMode  = 2'd0;
  localparam logic [1:0] RegWordIs16 = 2'd1;
  localparam logic [1:0] RegLineDir  = 2'd2;

  localparam logic [15:0] AllOnesWord = 16'hFFFF;
  localparam logic [3:0]  LastBit8    = 4'd7;
  localparam logic [3:0]  LastBit16   = 4'd15;

  typedef struct packed {
    logic [1:0] spi_mode;
    logic       word_is_16;
    logic [1:0] line_direction;
  } cfg_t;

  typedef struct packed {
    logic mode_wr;
    logic idle_level;
  } mode_evt_t;

  typedef struct packed {
    logic        is_tick;
    logic [15:0] word;
    logic        sample;
  } item_t;

  typedef struct packed {
    logic        sck_level;
    logic        mosi_level;
    logic        mosi_drive;
    logic        busy_res;
    logic [15:0] rx_word;
    logic        word_done;
    logic        start_rejected;
  } res_t;

endpackage

/* sv/spi_master_shift_engine.sv */
`timescale 1ns / 1ps
// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    func, tx_word, tx_absent, miso_in, mosi_line_in
// out      out_valid_o / out_ready_i  sck_level, mosi_level, mosi_drive, busy_res,
//                                     rx_word, word_done, start_rejected
// cfg      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item per cycle sustained while out_ready_i is high; a result becomes valid
// after its item passes through the queue and then the output register of the shifter.
// The two-entry queue keeps accepting input for two items while a result waits;
// in_ready_o drops once the queue is full.
// Reset clears the transfer state and config registers; SCK idles low.
// cfg_ready_o is always high.
module spi_master_shift_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [1:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [15:0] tx_word_i,
  input  logic        tx_absent_i,
  input  logic        miso_in_i,
  input  logic        mosi_line_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        sck_level_o,
  output logic        mosi_level_o,
  output logic        mosi_drive_o,
  output logic        busy_res_o,
  output logic [15:0] rx_word_o,
  output logic        word_done_o,
  output logic        start_rejected_o
);

  spise_pkg::item_t     front_item;
  spise_pkg::item_t     queue_item;
  spise_pkg::cfg_t      cfg;
  spise_pkg::mode_evt_t mode_evt;
  spise_pkg::res_t      res;
  logic                 q_full;
  logic                 q_empty;
  logic                 back_ready;
  logic                 pop;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full;
  assign pop         = !q_empty && back_ready;

  spise_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .func_i,
    .tx_word_i,
    .tx_absent_i,
    .miso_in_i,
    .mosi_line_in_i,
    .item_o     (front_item),
    .cfg_o      (cfg),
    .mode_evt_o (mode_evt)
  );

  spise_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (in_valid_i && !q_full),
    .push_item_i (front_item),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .pop_i       (pop),
    .pop_item_o  (queue_item)
  );

  spise_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg),
    .mode_evt_i   (mode_evt),
    .item_valid_i (!q_empty),
    .item_i       (queue_item),
    .item_ready_o (back_ready),
    .res_valid_o  (out_valid_o),
    .res_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign sck_level_o      = res.sck_level;
  assign mosi_level_o     = res.mosi_level;
  assign mosi_drive_o     = res.mosi_drive;
  assign busy_res_o       = res.busy_res;
  assign rx_word_o        = res.rx_word;
  assign word_done_o      = res.word_done;
  assign start_rejected_o = res.start_rejected;

endmodule

/* sv/spise_front.sv */
`timescale 1ns / 1ps
module spise_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [1:0]            cfg_data_i,
  input  logic                  func_i,
  input  logic [15:0]           tx_word_i,
  input  logic                  tx_absent_i,
  input  logic                  miso_in_i,
  input  logic                  mosi_line_in_i,
  output spise_pkg::item_t      item_o,
  output spise_pkg::cfg_t       cfg_o,
  output spise_pkg::mode_evt_t  mode_evt_o
);

  spise_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        spise_pkg::RegSpiMode:  cfg_d.spi_mode       = cfg_data_i;
        spise_pkg::RegWordIs16: cfg_d.word_is_16     = cfg_data_i[0];
        spise_pkg::RegLineDir:  cfg_d.line_direction = cfg_data_i;
        default:                cfg_d                = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign mode_evt_o.mode_wr    = cfg_valid_i && (cfg_index_i == spise_pkg::RegSpiMode);
  assign mode_evt_o.idle_level = cfg_data_i[1];
  assign cfg_o                 = cfg_q;

  always_comb begin
    item_o.is_tick = (func_i == spise_pkg::FuncTick);
    if (tx_absent_i) begin
      item_o.word = spise_pkg::AllOnesWord;
    end else if (cfg_q.word_is_16) begin
      item_o.word = tx_word_i;
    end else begin
      item_o.word = {8'h00, tx_word_i[7:0]};
    end
    item_o.sample = (cfg_q.line_direction == spise_pkg::DirRxOneLine) ? mosi_line_in_i
                                                                       : miso_in_i;
  end

endmodule

/* sv/spise_queue.sv */
`timescale 1ns / 1ps
module spise_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  spise_pkg::item_t  push_item_i,
  output logic              full_o,
  output logic              empty_o,
  input  logic              pop_i,
  output spise_pkg::item_t  pop_item_o
);

  spise_pkg::item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* sv/spise_back.sv */
`timescale 1ns / 1ps
module spise_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  spise_pkg::cfg_t       cfg_i,
  input  spise_pkg::mode_evt_t  mode_evt_i,
  input  logic                  item_valid_i,
  input  spise_pkg::item_t      item_i,
  output logic                  item_ready_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output spise_pkg::res_t       res_o
);

  logic            active_q, active_d;
  logic [3:0]      bit_idx_q, bit_idx_d;
  logic            half_q, half_d;
  logic [15:0]     tx_q, tx_d;
  logic [15:0]     rx_q, rx_d;
  logic            sck_q, sck_d;
  logic            mosi_q, mosi_d;
  logic            res_valid_q;
  spise_pkg::res_t res_q, res_d;

  logic fire;
  logic idle;
  logic cpha;
  logic tx_bit;
  logic drives;
  logic samples;
  logic done;
  logic rejected;
  logic [15:0] rx_shifted;
  logic [15:0] rx_out;

  assign item_ready_o = !res_valid_q || res_ready_i;
  assign fire         = item_valid_i && item_ready_o;
  assign idle         = cfg_i.spi_mode[1];
  assign cpha         = cfg_i.spi_mode[0];
  assign tx_bit       = tx_q[bit_idx_q];
  assign drives       = (cfg_i.line_direction == spise_pkg::DirFullDuplex) ||
                        (cfg_i.line_direction == spise_pkg::DirTxOneLine);
  assign samples      = (cfg_i.line_direction != spise_pkg::DirTxOneLine);
  assign rx_shifted   = samples ? {rx_q[14:0], item_i.sample} : rx_q;

  always_comb begin
    active_d  = active_q;
    bit_idx_d = bit_idx_q;
    half_d    = half_q;
    tx_d      = tx_q;
    rx_d      = rx_q;
    sck_d     = sck_q;
    mosi_d    = mosi_q;
    done      = 1'b0;
    rejected  = 1'b0;
    rx_out    = '0;
    if (fire) begin
      if (!item_i.is_tick) begin
        if (active_q) begin
          rejected = 1'b1;
        end else begin
          tx_d      = item_i.word;
          rx_d      = '0;
          bit_idx_d = cfg_i.word_is_16 ? spise_pkg::LastBit16 : spise_pkg::LastBit8;
          half_d    = 1'b0;
          active_d  = 1'b1;
          sck_d     = idle;
        end
      end else if (!active_q) begin
        sck_d = idle;
      end else if (!half_q) begin
        sck_d  = cpha ? ~idle : idle;
        mosi_d = drives ? tx_bit : mosi_q;
        half_d = 1'b1;
      end else begin
        sck_d  = cpha ? idle : ~idle;
        rx_d   = rx_shifted;
        half_d = 1'b0;
        if (bit_idx_q == 4'd0) begin
          done     = 1'b1;
          active_d = 1'b0;
          if (samples) begin
            rx_out = cfg_i.word_is_16 ? rx_shifted : {8'h00, rx_shifted[7:0]};
          end
        end else begin
          bit_idx_d = bit_idx_q - 4'd1;
        end
      end
    end else if (mode_evt_i.mode_wr && !active_q) begin
      sck_d = mode_evt_i.idle_level;
    end
  end

  always_comb begin
    res_d.sck_level      = sck_d;
    res_d.mosi_level     = mosi_d;
    res_d.mosi_drive     = (cfg_i.line_direction != spise_pkg::DirRxOneLine);
    res_d.busy_res       = active_d;
    res_d.rx_word        = rx_out;
    res_d.word_done      = done;
    res_d.start_rejected = rejected;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      bit_idx_q   <= 4'd0;
      half_q      <= 1'b0;
      tx_q        <= '0;
      rx_q        <= '0;
      sck_q       <= 1'b0;
      mosi_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      bit_idx_q   <= bit_idx_d;
      half_q      <= half_d;
      tx_q        <= tx_d;
      rx_q        <= rx_d;
      sck_q       <= sck_d;
      mosi_q      <= mosi_d;
      res_valid_q <= fire || (res_valid_q && !res_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
